FILE: src/bds_pkg.sv
package bds_pkg;

    localparam int PIX_W    = 8;
    localparam int PIX_MAX  = 255;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 12;
    localparam int HEIGHT_W = 12;
    localparam int FREG_W   = 5;

    localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_BLOCK_FACTOR = 2'd2;

    localparam logic [CFG_DW-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_DW-1:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [FREG_W-1:0] RST_BLOCK_FACTOR = 5'd2;

    typedef logic [PIX_W-1:0] t_pix;

endpackage

FILE: src/bds_ram.sv
module bds_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/bds_fifo.sv
module bds_fifo #(
    parameter int WIDTH = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    // two entries
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = r_count[1];
    assign o_empty = (r_count == 2'd0);

endmodule

FILE: src/bds_front.sv
module bds_front import bds_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_FACTOR = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [$clog2(MAX_WIDTH):0]         i_width,
    input  logic [HEIGHT_W-1:0]                i_height,
    input  logic [$clog2(MAX_FACTOR+1)-1:0]    i_factor,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [3*PIX_W-1:0]                 i_data,
    output logic                               o_push,
    output logic [3*(PIX_W+2*$clog2(MAX_FACTOR)):0] o_push_data,
    input  logic                               i_full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int SW = PIX_W + 2 * $clog2(MAX_FACTOR);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_ACC  = 1'b1;

    logic            r_state, n_state;
    logic [CW-1:0]   r_col, r_bc;
    logic [FW-1:0]   r_cib, r_rib;
    logic [HEIGHT_W-1:0] r_row;
    logic [3*PIX_W-1:0] r_px;
    logic            r_first, r_emit, r_last;
    logic [CW-1:0]   r_addr;
    logic            accept;
    logic            col_wrap, row_wrap, cib_wrap, rib_wrap;
    logic            leave;
    logic [3*SW-1:0] rd_data, wr_data;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    assign col_wrap = ((CW+1)'(r_col) + (CW+1)'(1)) >= i_width;
    assign row_wrap = ((HEIGHT_W+1)'(r_row) + (HEIGHT_W+1)'(1)) >= (HEIGHT_W+1)'(i_height);
    assign cib_wrap = (r_cib + FW'(1)) >= i_factor;
    assign rib_wrap = (r_rib + FW'(1)) >= i_factor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_bc    <= '0;
            r_cib   <= '0;
            r_row   <= '0;
            r_rib   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_bc  <= '0;
                    r_cib <= '0;
                    if (row_wrap) begin
                        r_row <= '0;
                        r_rib <= '0;
                    end else begin
                        r_row <= r_row + HEIGHT_W'(1);
                        r_rib <= rib_wrap ? '0 : r_rib + FW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                    if (cib_wrap) begin
                        r_cib <= '0;
                        r_bc  <= r_bc + CW'(1);
                    end else begin
                        r_cib <= r_cib + FW'(1);
                    end
                end
            end
        end
    end

    // a full block ends here when both in-block counters sit on their last slot;
    // it is the frame's last one when no further whole block fits right or below
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px    <= i_data;
            r_addr  <= r_bc;
            r_first <= (r_cib == '0) && (r_rib == '0);
            r_emit  <= cib_wrap && rib_wrap;
            r_last  <= (((CW+2)'(r_col) + (CW+2)'(i_factor)) >= (CW+2)'(i_width)) &&
                       (((HEIGHT_W+1)'(r_row) + (HEIGHT_W+1)'(i_factor))
                        >= (HEIGHT_W+1)'(i_height));
        end
    end

    assign leave = (r_state == S_ACC) && (!r_emit || !i_full);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_ACC;
            S_ACC:  if (leave) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_first) begin
                wr_data[k*SW +: SW] = SW'(r_px[k*PIX_W +: PIX_W]);
            end else begin
                wr_data[k*SW +: SW] = rd_data[k*SW +: SW] + SW'(r_px[k*PIX_W +: PIX_W]);
            end
        end
    end

    bds_ram #(
        .WIDTH (3 * SW),
        .DEPTH (MAX_WIDTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (leave),
        .i_waddr (r_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (r_bc),
        .o_rdata (rd_data)
    );

    assign o_push      = leave && r_emit;
    assign o_push_data = {r_last, wr_data};

endmodule

FILE: src/bds_div.sv
module bds_div import bds_pkg::*; #(
    parameter int MAX_FACTOR = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [$clog2(MAX_FACTOR+1)-1:0]         i_factor,
    input  logic                                    i_empty,
    input  logic [3*(PIX_W+2*$clog2(MAX_FACTOR)):0] i_data,
    output logic                                    o_pop,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic [3*PIX_W-1:0]                      o_data,
    output logic                                    o_last
);

    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int AW = 2 * FW;
    localparam int SW = PIX_W + 2 * $clog2(MAX_FACTOR);
    localparam int NW = (SW > 1) ? $clog2(SW) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]      r_state, n_state;
    logic [AW-1:0]   r_area;
    logic [SW-1:0]   r_q   [3];
    logic [AW-1:0]   r_rem [3];
    logic [SW-1:0]   n_q   [3];
    logic [AW-1:0]   n_rem [3];
    logic [AW:0]     trial [3];
    logic [NW-1:0]   r_cnt;
    logic            r_last_d;
    logic            r_valid;
    logic [3*PIX_W-1:0] r_out;
    logic            r_out_last;
    logic            load_out;

    always_ff @(posedge i_clk) begin
        r_area <= AW'(i_factor) * AW'(i_factor);
    end

    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign load_out = (r_state == S_OUT) && (!r_valid || i_ready);

    // restoring division, one quotient bit per cycle for each channel
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            trial[k] = {r_rem[k], r_q[k][SW-1]};
            if (trial[k] >= {1'b0, r_area}) begin
                n_rem[k] = AW'(trial[k] - {1'b0, r_area});
                n_q[k]   = {r_q[k][SW-2:0], 1'b1};
            end else begin
                n_rem[k] = trial[k][AW-1:0];
                n_q[k]   = {r_q[k][SW-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (o_pop) n_state = S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_OUT;
            S_OUT:  if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k]   <= i_data[k*SW +: SW];
                r_rem[k] <= '0;
            end
            r_last_d <= i_data[3*SW];
            r_cnt    <= NW'(SW - 1);
        end else if (r_state == S_DIV) begin
            for (int k = 0; k < 3; k++) begin
                r_q[k]   <= n_q[k];
                r_rem[k] <= n_rem[k];
            end
            r_cnt <= r_cnt - NW'(1);
        end
        if (load_out) begin
            for (int k = 0; k < 3; k++) begin
                r_out[k*PIX_W +: PIX_W] <= (r_q[k] > SW'(PIX_MAX)) ? t_pix'(PIX_MAX)
                                                                  : r_q[k][PIX_W-1:0];
            end
            r_out_last <= r_last_d;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;
    assign o_last  = r_out_last;

endmodule

FILE: src/box_downsample_rgb_top.sv
// Box-filter downscaler for 8-bit RGB in raster order: each output pixel is the
// truncated per-channel mean of a factor-by-factor block, sent when the block's
// bottom-right pixel arrives; tlast marks the frame's last output. The front
// takes a pixel only while idle: it reads the column sum memory (MAX_WIDTH
// entries), then adds and writes back, waiting while a finished block finds the
// queue full. Each output then holds the bit-serial divider (pop, one quotient
// bit per cycle, output load, which waits while the output is stalled), behind
// a two-entry queue that stalls the front when full. At factors above 1 only the
// bottom row of each block band emits outputs and can be held back by the
// divider. Configure geometry between frames only.
module box_downsample_rgb_top import bds_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_FACTOR = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // red_in, green_in, blue_in
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // red_out, green_out, blue_out
    output logic              m_axis_tlast    // frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int FW = $clog2(MAX_FACTOR + 1);
    localparam int SW = PIX_W + 2 * $clog2(MAX_FACTOR);
    localparam int QW = 3 * SW + 1;

    logic [CFG_DW-1:0]   r_width, r_height;
    logic [FREG_W-1:0]   r_factor;
    logic [CW:0]         eff_width;
    logic [HEIGHT_W-1:0] eff_height;
    logic [FW-1:0]       eff_factor;
    logic                push, pop, full, empty;
    logic [QW-1:0]       push_data, pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_factor <= RST_BLOCK_FACTOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                CFG_BLOCK_FACTOR: r_factor <= i_cfg_data[FREG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            eff_width = (CW+1)'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            eff_width = (CW+1)'(MAX_WIDTH);
        end else begin
            eff_width = (CW+1)'(r_width);
        end
        eff_height = (r_height == '0) ? HEIGHT_W'(1) : HEIGHT_W'(r_height);
        if (r_factor == '0) begin
            eff_factor = FW'(1);
        end else if (32'(r_factor) > MAX_FACTOR) begin
            eff_factor = FW'(MAX_FACTOR);
        end else begin
            eff_factor = FW'(r_factor);
        end
    end

    bds_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (eff_width),
        .i_height    (eff_height),
        .i_factor    (eff_factor),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (full)
    );

    bds_fifo #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_full  (full),
        .o_empty (empty)
    );

    bds_div #(
        .MAX_FACTOR (MAX_FACTOR)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_factor (eff_factor),
        .i_empty  (empty),
        .i_data   (pop_data),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata),
        .o_last   (m_axis_tlast)
    );

endmodule

FILE: src/bds_checker.sv
module bds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // nothing is shown in the cycle after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // the front takes no new pixel during the sum write-back
    a_front_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("pixel taken on back-to-back cycles");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output transfer changed");

endmodule

bind box_downsample_rgb_top bds_checker u_bds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
